>>> rtl/core/ckrt_pkg.sv
// Package for the compacting keyed record table.
// Holds table sizes, field widths, request and status codes, and the command struct.
// Used by ckrt_ctrl, ckrt_datapath and compacting_keyed_record_table.
package ckrt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int REQ_W       = 2;
    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 64;
    localparam int STATUS_W    = 2;
    localparam int FIDX_W      = 6;
    localparam int FILL_W      = 7;

    localparam int S_TDATA_W   = ((KEY_W + VALUE_W + 7) / 8) * 8;
    localparam int M_PAYLOAD_W = VALUE_W + FIDX_W + FILL_W;
    localparam int M_TDATA_W   = ((M_PAYLOAD_W + 7) / 8) * 8;
    localparam int S_TUSER_W   = REQ_W;
    localparam int M_TUSER_W   = STATUS_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_UPDATE = 2'd2,
        REQ_DELETE = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic capture;
        logic select;
        logic execute;
    } ckrt_cmd_t;

endpackage

>>> rtl/core/ckrt_ctrl.sv
// Controller for the compacting keyed record table.
// Sequences capture/match, hit select and execute; owns the result valid flag.
// Depends on ckrt_pkg.
module ckrt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output ckrt_pkg::ckrt_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SELECT,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    assign s_tready    = (state_reg == S_IDLE);
    assign m_tvalid    = m_tvalid_reg;

    assign cmd.capture = s_tvalid && (state_reg == S_IDLE);
    assign cmd.select  = (state_reg == S_SELECT);
    assign cmd.execute = (state_reg == S_EXEC) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_SELECT;
                end
            end
            S_SELECT:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

>>> rtl/core/ckrt_datapath.sv
// Datapath for the compacting keyed record table.
// Cell array with parallel key match, lowest-hit select, shift-down delete, result regs.
// Depends on ckrt_pkg; commanded by ckrt_ctrl.
module ckrt_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ckrt_pkg::ckrt_cmd_t            cmd,
    input  logic [ckrt_pkg::REQ_W-1:0]     req_in,
    input  logic [ckrt_pkg::KEY_W-1:0]     key_in,
    input  logic [ckrt_pkg::VALUE_W-1:0]   value_in,
    output logic [ckrt_pkg::STATUS_W-1:0]  status,
    output logic [ckrt_pkg::VALUE_W-1:0]   found_value,
    output logic [ckrt_pkg::FIDX_W-1:0]    found_index,
    output logic [ckrt_pkg::FILL_W-1:0]    fill_count
);

    localparam int DEPTH = ckrt_pkg::TABLE_DEPTH;

    logic [ckrt_pkg::KEY_W-1:0]   keys_reg [DEPTH];
    logic [ckrt_pkg::VALUE_W-1:0] vals_reg [DEPTH];
    logic [ckrt_pkg::CNT_W-1:0]   count_reg;
    logic [ckrt_pkg::CNT_W-1:0]   count_next;

    ckrt_pkg::req_type_t          req_reg;
    logic [ckrt_pkg::KEY_W-1:0]   key_reg;
    logic [ckrt_pkg::VALUE_W-1:0] val_reg;
    logic [DEPTH-1:0]             match_reg;

    logic [DEPTH-1:0]             first_oh;
    logic [DEPTH-1:0]             hit_oh_reg;
    logic [DEPTH-1:0]             shift_mask_reg;
    logic                         hit_reg;
    logic [ckrt_pkg::IDX_W-1:0]   hit_idx;
    logic [ckrt_pkg::IDX_W-1:0]   hit_idx_reg;
    logic [ckrt_pkg::VALUE_W-1:0] hit_val;
    logic [ckrt_pkg::VALUE_W-1:0] hit_val_reg;

    logic                         full;
    logic                         do_insert;
    logic                         do_update;
    logic                         do_delete;
    ckrt_pkg::status_t            status_next;
    logic [ckrt_pkg::VALUE_W-1:0] fval_next;
    logic [ckrt_pkg::FIDX_W-1:0]  fidx_next;

    ckrt_pkg::status_t            status_reg;
    logic [ckrt_pkg::VALUE_W-1:0] fval_reg;
    logic [ckrt_pkg::FIDX_W-1:0]  fidx_reg;
    logic [ckrt_pkg::FILL_W-1:0]  fill_reg;

    // capture: request and per-cell match against the live table
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= ckrt_pkg::req_type_t'(req_in);
            key_reg <= key_in;
            val_reg <= value_in;
            for (int i = 0; i < DEPTH; i++)
            begin
                match_reg[i] <= (keys_reg[i] == key_in)
                                && (ckrt_pkg::CNT_W'(i) < count_reg);
            end
        end
    end

    // lowest matching cell
    always_comb
    begin
        first_oh = match_reg & (~match_reg + DEPTH'(1));
        hit_idx  = '0;
        hit_val  = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_idx = hit_idx | (first_oh[i] ? ckrt_pkg::IDX_W'(i) : '0);
            hit_val = hit_val | (first_oh[i] ? vals_reg[i] : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.select)
        begin
            hit_reg        <= |match_reg;
            hit_oh_reg     <= first_oh;
            shift_mask_reg <= ~(first_oh - DEPTH'(1));
            hit_idx_reg    <= hit_idx;
            hit_val_reg    <= hit_val;
        end
    end

    // execute
    always_comb
    begin
        full        = (count_reg == ckrt_pkg::CNT_W'(DEPTH));
        do_insert   = 1'b0;
        do_update   = 1'b0;
        do_delete   = 1'b0;
        count_next  = count_reg;
        status_next = ckrt_pkg::ST_OK;
        fval_next   = '0;
        fidx_next   = ckrt_pkg::FIDX_W'(hit_idx_reg);
        case (req_reg)
            ckrt_pkg::REQ_INSERT:
            begin
                if (hit_reg)
                begin
                    status_next = ckrt_pkg::ST_DUPLICATE;
                end
                else if (full)
                begin
                    status_next = ckrt_pkg::ST_FULL;
                    fidx_next   = '0;
                end
                else
                begin
                    do_insert  = 1'b1;
                    fidx_next  = ckrt_pkg::FIDX_W'(count_reg);
                    count_next = count_reg + ckrt_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                if (!hit_reg)
                begin
                    status_next = ckrt_pkg::ST_NOT_FOUND;
                    fidx_next   = '0;
                end
                else if (req_reg == ckrt_pkg::REQ_LOOKUP)
                begin
                    fval_next = hit_val_reg;
                end
                else if (req_reg == ckrt_pkg::REQ_UPDATE)
                begin
                    do_update = 1'b1;
                end
                else
                begin
                    do_delete  = 1'b1;
                    count_next = count_reg - ckrt_pkg::CNT_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (do_insert && (ckrt_pkg::CNT_W'(i) == count_reg))
                begin
                    keys_reg[i] <= key_reg;
                    vals_reg[i] <= val_reg;
                end
                else if (do_update && hit_oh_reg[i])
                begin
                    vals_reg[i] <= val_reg;
                end
                else if (do_delete && shift_mask_reg[i] && (i < DEPTH - 1))
                begin
                    keys_reg[i] <= keys_reg[(i < DEPTH - 1) ? i + 1 : i];
                    vals_reg[i] <= vals_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
            status_reg <= status_next;
            fval_reg   <= fval_next;
            fidx_reg   <= fidx_next;
            fill_reg   <= ckrt_pkg::FILL_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    assign status      = status_reg;
    assign found_value = fval_reg;
    assign found_index = fidx_reg;
    assign fill_count  = fill_reg;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ckrt_pkg::CNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute && hit_reg |-> $onehot(hit_oh_reg))
        else $error("hit select not one-hot");

    a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute && do_delete |=> count_reg == $past(count_reg) - ckrt_pkg::CNT_W'(1))
        else $error("delete did not shrink the table");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute && do_insert |=> count_reg == $past(count_reg) + ckrt_pkg::CNT_W'(1))
        else $error("insert did not grow the table");
`endif

endmodule

>>> rtl/core/compacting_keyed_record_table.sv
// Top level of the compacting keyed record table.
// Instantiates ckrt_ctrl and ckrt_datapath; depends on ckrt_pkg.
//
// A request (insert, lookup, update, delete on a 32-bit key) is taken when the
// block is idle and gives exactly one result. Each request passes capture
// with a parallel key match in every cell, a lowest-hit select over the match
// vector, then the table write (append, overwrite, or shift-down delete) with
// the result loaded into the output register; the write waits while an older
// result is not yet taken. A waiting result does not block the next request from entering.
// The entries need no clearing after reset; only the fill count is reset.
module compacting_keyed_record_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ckrt_pkg::S_TDATA_W-1:0]  s_tdata,  // key, record_value
    input  logic [ckrt_pkg::S_TUSER_W-1:0]  s_tuser,  // req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ckrt_pkg::M_TDATA_W-1:0]  m_tdata,  // found_value, found_index, fill_count
    output logic [ckrt_pkg::M_TUSER_W-1:0]  m_tuser   // status
);

    ckrt_pkg::ckrt_cmd_t                 cmd;
    logic signed [ckrt_pkg::KEY_W-1:0]   key;
    logic [ckrt_pkg::VALUE_W-1:0]        record_value;
    logic [ckrt_pkg::VALUE_W-1:0]        found_value;
    logic [ckrt_pkg::FIDX_W-1:0]         found_index;
    logic [ckrt_pkg::FILL_W-1:0]         fill_count;

    assign key          = s_tdata[ckrt_pkg::KEY_W-1:0];
    assign record_value = s_tdata[ckrt_pkg::KEY_W +: ckrt_pkg::VALUE_W];

    assign m_tdata = ckrt_pkg::M_TDATA_W'({fill_count, found_index, found_value});

    ckrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ckrt_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_in      (s_tuser),
        .key_in      (key),
        .value_in    (record_value),
        .status      (m_tuser),
        .found_value (found_value),
        .found_index (found_index),
        .fill_count  (fill_count)
    );

endmodule
